[hdl/huffman_tree_builder_defines.svh]
// Assertion macros for the Huffman tree builder.
`ifndef HUFFMAN_TREE_BUILDER_DEFINES_SVH
`define HUFFMAN_TREE_BUILDER_DEFINES_SVH
`ifndef SYNTH
`define HUFB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("assertion failed");
`define HUFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define HUFB_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define HUFB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/hufb_pkg.sv]
// Shared types, constants and ordering function for the Huffman tree builder.
package hufb_pkg;
	localparam int DEF_MAX_SYMBOLS = 64;
	localparam int FREQ_W = 24;
	localparam int WEIGHT_W = 30;
	localparam int ID_W = 7;

	typedef struct packed {
		logic [WEIGHT_W-1:0] w;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		logic en;
		logic first;
	} trk_ctrl_t;

	// true when a is removed before b
	function automatic logic goes_first(entry_t a, entry_t b);
		logic r;
		if (a.w != b.w) r = (a.w < b.w);
		else r = (a.id > b.id);
		return r;
	endfunction
endpackage

[hdl/hufb_track.sv]
// Running tracker of the two first-ordered entries during a scan.
module hufb_track #(
	parameter int AW = 6
) (
	input  logic             clk,
	input  hufb_pkg::trk_ctrl_t ctrl,
	input  hufb_pkg::entry_t e,
	input  logic [AW-1:0]    e_idx,
	output hufb_pkg::entry_t b1,
	output hufb_pkg::entry_t b2,
	output logic [AW-1:0]    p1,
	output logic [AW-1:0]    p2
);
	import hufb_pkg::*;

	entry_t b1_q, b2_q;
	logic [AW-1:0] p1_q, p2_q;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (ctrl.first || goes_first(e, b1_q)) begin
				b1_q <= e;
				p1_q <= e_idx;
				b2_q <= b1_q;
				p2_q <= p1_q;
			end else if (e_idx == AW'(1) || goes_first(e, b2_q)) begin
				b2_q <= e;
				p2_q <= e_idx;
			end
		end
	end

	assign b1 = b1_q;
	assign b2 = b2_q;
	assign p1 = p1_q;
	assign p2 = p2_q;
endmodule

[hdl/huffman_tree_builder.sv]
// Huffman tree builder top level: symbol store, merge sequencer and result registers.
// Frequencies load one per cycle while busy is low. The request marked last starts the
// build, with busy high until the root record: each merge scans all n live entries
// through one registered memory read port and one compare unit, plus a read and a
// move step when the last entry must be moved into a freed slot. Each record shows for
// one cycle on res_valid and cannot be held off. A lone symbol gives its single record
// in the cycle after the request, without raising busy.
module huffman_tree_builder #(
	parameter int MAX_SYMBOLS = hufb_pkg::DEF_MAX_SYMBOLS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [hufb_pkg::FREQ_W-1:0]   freq,
	input  logic                          last,
	output logic                          res_valid,
	output logic [hufb_pkg::ID_W-1:0]     node_id,
	output logic [hufb_pkg::ID_W-1:0]     left_id,
	output logic [hufb_pkg::ID_W-1:0]     right_id,
	output logic [hufb_pkg::WEIGHT_W-1:0] weight,
	output logic                          single,
	output logic                          done_res
);
	import hufb_pkg::*;
	`include "huffman_tree_builder_defines.svh"

	localparam int AW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int CW = $clog2(MAX_SYMBOLS + 1);

	typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_MERGE, ST_RDL, ST_MOVE} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q, k_q;
	logic [ID_W-1:0] next_id_q;
	logic v_s1;
	logic [AW-1:0] idx_s1;

	entry_t mem [MAX_SYMBOLS];
	entry_t rd_data_q, wd;
	logic [AW-1:0] ra, wa;
	logic we;

	entry_t b1, b2, merged;
	logic [AW-1:0] p1, p2, lidx;
	trk_ctrl_t tctrl;

	logic accept;
	logic [WEIGHT_W-1:0] fw;
	logic [CW-1:0] cnt_new;

	assign accept = start && !busy;
	assign fw = (freq == '0) ? WEIGHT_W'(1) : WEIGHT_W'(freq);
	assign cnt_new = (cnt_q < CW'(MAX_SYMBOLS)) ? cnt_q + CW'(1) : cnt_q;
	assign lidx = AW'(cnt_q - CW'(1));
	assign merged.w = b1.w + b2.w;
	assign merged.id = next_id_q;
	assign busy = (state_q != ST_IDLE);

	assign tctrl.en = v_s1;
	assign tctrl.first = (idx_s1 == '0);

	hufb_track #(.AW(AW)) u_track (
		.clk(clk), .ctrl(tctrl), .e(rd_data_q), .e_idx(idx_s1),
		.b1(b1), .b2(b2), .p1(p1), .p2(p2)
	);

	always_comb begin
		we = 1'b0;
		wa = AW'(cnt_q);
		wd.w = fw;
		wd.id = ID_W'(cnt_q);
		ra = AW'(k_q);
		unique case (state_q)
			ST_IDLE: we = accept && (cnt_q < CW'(MAX_SYMBOLS));
			ST_MERGE: begin
				we = (cnt_q != CW'(2));
				wd = merged;
				wa = (p1 == lidx) ? p2 : p1;
			end
			ST_RDL: ra = lidx;
			ST_MOVE: begin
				we = 1'b1;
				wd = rd_data_q;
				wa = p2;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_data_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			k_q <= '0;
			next_id_q <= '0;
			v_s1 <= 1'b0;
			idx_s1 <= '0;
			res_valid <= 1'b0;
			node_id <= '0;
			left_id <= '0;
			right_id <= '0;
			weight <= '0;
			single <= 1'b0;
			done_res <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			v_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last && cnt_q == '0) begin
							res_valid <= 1'b1;
							node_id <= '0;
							left_id <= '0;
							right_id <= '0;
							weight <= fw;
							single <= 1'b1;
							done_res <= 1'b1;
						end else begin
							cnt_q <= cnt_new;
							if (last) begin
								next_id_q <= ID_W'(cnt_new);
								k_q <= '0;
								state_q <= ST_SCAN;
							end
						end
					end
				end
				ST_SCAN: begin
					if (k_q < cnt_q) begin
						v_s1 <= 1'b1;
						idx_s1 <= AW'(k_q);
						k_q <= k_q + CW'(1);
					end
					if (v_s1 && idx_s1 == lidx) state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					res_valid <= 1'b1;
					node_id <= next_id_q;
					left_id <= b1.id;
					right_id <= b2.id;
					weight <= merged.w;
					single <= 1'b0;
					done_res <= (cnt_q == CW'(2));
					k_q <= '0;
					if (cnt_q == CW'(2)) begin
						cnt_q <= '0;
						next_id_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						next_id_q <= next_id_q + ID_W'(1);
						if (p1 != lidx && p2 != lidx) begin
							state_q <= ST_RDL;
						end else begin
							cnt_q <= cnt_q - CW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_RDL: state_q <= ST_MOVE;
				ST_MOVE: begin
					cnt_q <= cnt_q - CW'(1);
					state_q <= ST_SCAN;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`HUFB_ASSERT_NEXT(a_root_idle, clk, arst_n, res_valid && done_res, !busy)
	`HUFB_ASSERT_NEXT(a_load_quiet, clk, arst_n, start && !busy && !last, !res_valid)
	`HUFB_ASSERT_SAME(a_single_root, clk, arst_n, res_valid && single, done_res)
	`HUFB_ASSERT_SAME(a_merge_busy, clk, arst_n, res_valid && !single, !$past(state_q == ST_IDLE))
endmodule

[tb/huffman_tree_builder_tb.sv]
// Self-checking testbench for the Huffman tree builder: directed table plus random runs.
`timescale 1ns / 1ps

module huffman_tree_builder_tb;
	import hufb_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]     node;
		logic [ID_W-1:0]     lft;
		logic [ID_W-1:0]     rgt;
		logic [WEIGHT_W-1:0] w;
		logic                sgl;
		logic                dn;
	} merge_rec_t;

	typedef struct {
		logic [FREQ_W-1:0] f;
		logic              lst;
		logic              chk;
		merge_rec_t        rec;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [FREQ_W-1:0]   freq;
	logic                last;
	logic                res_valid;
	logic [ID_W-1:0]     node_id;
	logic [ID_W-1:0]     left_id;
	logic [ID_W-1:0]     right_id;
	logic [WEIGHT_W-1:0] weight;
	logic                single;
	logic                done_res;

	logic [WEIGHT_W-1:0] sym_w[64];
	logic [ID_W-1:0]     sym_id[64];
	int                  sym_cnt;
	merge_rec_t          pending_recs[$];
	int                  mismatches;
	int                  fails;

	huffman_tree_builder i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .freq(freq), .last(last),
		.res_valid(res_valid), .node_id(node_id), .left_id(left_id), .right_id(right_id),
		.weight(weight), .single(single), .done_res(done_res)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic int lowest_entry();
		int best;
		best = 0;
		for (int k = 1; k < sym_cnt; k++)
			if (sym_w[k] != sym_w[best] ? sym_w[k] < sym_w[best] : sym_id[k] > sym_id[best])
				best = k;
		return best;
	endfunction

	task automatic pop_lowest(output logic [ID_W-1:0] id, output logic [WEIGHT_W-1:0] w);
		int b;
		b = lowest_entry();
		id = sym_id[b];
		w = sym_w[b];
		sym_cnt--;
		sym_w[b] = sym_w[sym_cnt];
		sym_id[b] = sym_id[sym_cnt];
	endtask

	// appends the predicted records to pending_recs when the request closes a tree
	task automatic predict_tree(input logic [FREQ_W-1:0] f, input logic lst);
		logic [ID_W-1:0]     ia, ib, nid;
		logic [WEIGHT_W-1:0] wa, wb;
		merge_rec_t          r;
		if (sym_cnt < 64) begin
			sym_w[sym_cnt] = (f == '0) ? WEIGHT_W'(1) : WEIGHT_W'(f);
			sym_id[sym_cnt] = ID_W'(sym_cnt);
			sym_cnt++;
		end
		if (lst) begin
			nid = ID_W'(sym_cnt);
			if (sym_cnt == 1) begin
				r = '{node: 0, lft: 0, rgt: 0, w: sym_w[0], sgl: 1'b1, dn: 1'b1};
				pending_recs = {pending_recs, r};
			end else begin
				while (sym_cnt > 1) begin
					pop_lowest(ia, wa);
					pop_lowest(ib, wb);
					r.w = wa + wb;
					sym_w[sym_cnt] = r.w;
					sym_id[sym_cnt] = nid;
					sym_cnt++;
					r.node = nid;
					r.lft = ia;
					r.rgt = ib;
					r.sgl = 1'b0;
					r.dn = (sym_cnt == 1);
					pending_recs = {pending_recs, r};
					nid++;
				end
			end
			sym_cnt = 0;
		end
	endtask

	task automatic send_request(input logic [FREQ_W-1:0] f, input logic lst, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		freq <= f;
		last <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_tree(f, lst);
	endtask

	always @(posedge clk) begin
		merge_rec_t got, exp_rec;
		if (arst_n && res_valid) begin
			got = '{node: node_id, lft: left_id, rgt: right_id, w: weight, sgl: single,
				dn: done_res};
			if (pending_recs.size() == 0) begin
				fails++;
				if (mismatches < 10) $display("unexpected record %p", got);
				mismatches++;
			end else begin
				exp_rec = pending_recs.pop_front();
				if (got !== exp_rec) begin
					fails++;
					if (mismatches < 10) $display("mismatch: expected %p actual %p", exp_rec, got);
					mismatches++;
				end
			end
		end
	end

	stim_row_t dir_rows[$];
	merge_rec_t typed_recs[$];

	function automatic stim_row_t row(logic [FREQ_W-1:0] f, logic l);
		stim_row_t s;
		s.f = f;
		s.lst = l;
		s.chk = 1'b0;
		s.rec = '0;
		return s;
	endfunction

	initial begin
		int n;
		stim_row_t s;
		start = 1'b0;
		freq = '0;
		last = 1'b0;
		arst_n = 1'b0;
		sym_cnt = 0;
		mismatches = 0;
		fails = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone symbols: zero freq, max freq
		s = row(24'd0, 1'b1);
		s.chk = 1'b1;
		s.rec = '{node: 0, lft: 0, rgt: 0, w: 1, sgl: 1, dn: 1};
		dir_rows = {dir_rows, s};
		s = row(24'hFFFFFF, 1'b1);
		s.chk = 1'b1;
		s.rec = '{node: 0, lft: 0, rgt: 0, w: 30'hFFFFFF, sgl: 1, dn: 1};
		dir_rows = {dir_rows, s};
		// two max symbols: tie goes to higher id first
		dir_rows = {dir_rows, row(24'hFFFFFF, 1'b0)};
		s = row(24'hFFFFFF, 1'b1);
		s.chk = 1'b1;
		s.rec = '{node: 2, lft: 1, rgt: 0, w: 30'h1FFFFFE, sgl: 0, dn: 1};
		dir_rows = {dir_rows, s};
		// mixed small run with zeros and ties
		dir_rows = {dir_rows, row(24'd5, 1'b0)};
		dir_rows = {dir_rows, row(24'd0, 1'b0)};
		dir_rows = {dir_rows, row(24'd1, 1'b0)};
		dir_rows = {dir_rows, row(24'h800000, 1'b0)};
		dir_rows = {dir_rows, row(24'h7FFFFF, 1'b0)};
		dir_rows = {dir_rows, row(24'h555555, 1'b0)};
		dir_rows = {dir_rows, row(24'hAAAAAA, 1'b1)};

		foreach (dir_rows[i]) begin
			s = dir_rows[i];
			send_request(s.f, s.lst, i % 3);
			if (s.chk) begin
				merge_rec_t p;
				p = pending_recs[pending_recs.size() - 1];
				if (p !== s.rec) begin
					fails++;
					if (mismatches < 10) $display("mismatch: expected %p actual %p", s.rec, p);
					mismatches++;
				end
			end
		end

		// overflow: 70 symbols, last 6 dropped
		for (int i = 0; i < 70; i++)
			send_request($urandom_range(0, 3) == 0 ? 24'd0 : FREQ_W'($urandom), i == 69,
				$urandom_range(0, 10) > 8 ? $urandom_range(0, 10) : 0);

		start <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);

		// random runs of mostly small sizes
		n = 0;
		while (n < 30) begin
			int len;
			len = $urandom_range(1, 8);
			for (int i = 0; i < len; i++) begin
				logic [FREQ_W-1:0] f;
				case ($urandom_range(0, 3))
					0: f = FREQ_W'($urandom_range(0, 3));
					1: f = FREQ_W'(24'hFFFFFF - $urandom_range(0, 3));
					default: f = FREQ_W'($urandom);
				endcase
				send_request(f, i == len - 1, $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10));
				n++;
			end
		end

		start <= 1'b0;
		while (pending_recs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
